>>> rtl/core/ahcr_pkg.sv
// Shared constants and types for the averaged hysteresis charge relay.
package ahcr_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_index_type CSR_CHARGE_LIMIT   = 3'd0;
   localparam csr_index_type CSR_HYSTERESIS     = 3'd1;
   localparam csr_index_type CSR_INERTIA        = 3'd2;
   localparam csr_index_type CSR_VOLTAGE_GAIN   = 3'd3;
   localparam csr_index_type CSR_CURRENT_OFFSET = 3'd4;
   localparam csr_index_type CSR_CURRENT_GAIN   = 3'd5;

   // Register widths
   localparam int LIMIT_W   = 10;
   localparam int HYST_W    = 8;
   localparam int INERTIA_W = 16;
   localparam int GAIN_W    = 16;
   localparam int OFFSET_W  = 10;

   // Register reset values
   localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 10'd700;
   localparam logic [HYST_W-1:0]    HYST_RST    = 8'd5;
   localparam logic [INERTIA_W-1:0] INERTIA_RST = 16'd1000;
   localparam logic [GAIN_W-1:0]    GAIN_RST    = 16'd256;
   localparam logic [OFFSET_W-1:0]  OFFSET_RST  = 10'd512;

   // Timestamps and display values
   localparam int TIME_W = 32;
   localparam int DISP_W = 16;
   typedef logic [TIME_W-1:0] time_ms_type;
   typedef logic [DISP_W-1:0] disp_type;

   // Q8.8 scaling
   localparam int Q_FRAC     = 8;
   localparam int ROUND_HALF = 128;

   // Result queue
   localparam int RSP_FIFO_DEPTH = 8;

endpackage

>>> rtl/core/ahcr_if.sv
// Channel interfaces: sample words in, result words out, register writes.

interface ahcr_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                         valid;
   logic                         ready;
   logic [SAMPLE_BITS-1:0]       voltage_sample;
   logic [SAMPLE_BITS-1:0]       current_sample;
   ahcr_pkg::time_ms_type        now_ms;

   modport source(output valid, output voltage_sample, output current_sample,
                  output now_ms, input ready);
   modport sink(input valid, input voltage_sample, input current_sample,
                input now_ms, output ready);
endinterface

interface ahcr_rsp_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                         valid;
   logic                         ready;
   logic                         relay_on;
   logic [SAMPLE_BITS-1:0]       voltage_level;
   logic [SAMPLE_BITS-1:0]       current_level;
   ahcr_pkg::disp_type           voltage_display;
   ahcr_pkg::disp_type           current_display;

   modport source(output valid, output relay_on, output voltage_level,
                  output current_level, output voltage_display,
                  output current_display, input ready);
   modport sink(input valid, input relay_on, input voltage_level,
                input current_level, input voltage_display,
                input current_display, output ready);
endinterface

interface ahcr_csr_if;
   logic                         valid;
   logic                         ready;
   ahcr_pkg::csr_index_type      index;
   ahcr_pkg::csr_data_type       data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/core/ahcr_window.sv
// Sample window memory with running sums for both channels.
module ahcr_window #(
   parameter int WINDOW_LENGTH = 30,
   parameter int SAMPLE_BITS   = 10,
   parameter int SUM_W         = SAMPLE_BITS + $clog2(WINDOW_LENGTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [SAMPLE_BITS-1:0] voltage_sample,
   input  logic [SAMPLE_BITS-1:0] current_sample,
   output logic                   sum_valid,
   output logic [SUM_W-1:0]       voltage_sum,
   output logic [SUM_W-1:0]       current_sum
);

   localparam int POS_W = $clog2(WINDOW_LENGTH);
   localparam int ENT_W = 2 * SAMPLE_BITS;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_LENGTH - 1);
   localparam logic [SUM_W-1:0] SUM_MAX =
      SUM_W'(WINDOW_LENGTH * ((1 << SAMPLE_BITS) - 1));

   logic [ENT_W-1:0]         mem [WINDOW_LENGTH];
   logic [WINDOW_LENGTH-1:0] written_ff, written_in;

   logic [POS_W-1:0]       pos_ff, pos_in, rd_pos;
   logic                   upd_ff, upd_in;
   logic [SAMPLE_BITS-1:0] vs_ff, cs_ff;
   logic [ENT_W-1:0]       rd_data_ff;
   logic                   rd_written_ff;
   logic [SUM_W-1:0]       vsum_ff, vsum_in, csum_ff, csum_in;
   logic                   sum_vld_ff, sum_vld_in;
   logic [SAMPLE_BITS-1:0] old_v, old_c;

   // next slot; the oldest sample lives there
   assign rd_pos = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);

   always_comb begin
      pos_in     = accept ? rd_pos : pos_ff;
      upd_in     = accept;
      written_in = written_ff;
      if (upd_ff) begin
         written_in[pos_ff] = 1'b1;
      end
      // never-written slots read as zero
      old_v      = rd_written_ff ? rd_data_ff[SAMPLE_BITS-1:0] : '0;
      old_c      = rd_written_ff ? rd_data_ff[ENT_W-1:SAMPLE_BITS] : '0;
      vsum_in    = vsum_ff;
      csum_in    = csum_ff;
      if (upd_ff) begin
         vsum_in = vsum_ff - SUM_W'(old_v) + SUM_W'(vs_ff);
         csum_in = csum_ff - SUM_W'(old_c) + SUM_W'(cs_ff);
      end
      sum_vld_in = upd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         upd_ff     <= 1'b0;
         written_ff <= '0;
         vsum_ff    <= '0;
         csum_ff    <= '0;
         sum_vld_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         upd_ff     <= upd_in;
         written_ff <= written_in;
         vsum_ff    <= vsum_in;
         csum_ff    <= csum_in;
         sum_vld_ff <= sum_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vs_ff <= voltage_sample;
         cs_ff <= current_sample;
      end
   end

   // read port: oldest entry, registered
   always_ff @(posedge clock) begin
      rd_data_ff    <= mem[rd_pos];
      rd_written_ff <= written_ff[rd_pos];
   end

   // write port: new sample replaces the oldest
   always_ff @(posedge clock) begin
      if (upd_ff) begin
         mem[pos_ff] <= {cs_ff, vs_ff};
      end
   end

   assign sum_valid   = sum_vld_ff;
   assign voltage_sum = vsum_ff;
   assign current_sum = csum_ff;

`ifndef SYNTHESIS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (upd_ff && accept) |-> (rd_pos != pos_ff))
      else $error("window read and write hit the same slot");

   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      (vsum_ff <= SUM_MAX) && (csum_ff <= SUM_MAX))
      else $error("running sum out of range");

   a_sum_follows_write: assert property (@(posedge clock) disable iff (reset)
      upd_ff |=> sum_vld_ff)
      else $error("sum update lost");
`endif

endmodule

>>> rtl/core/ahcr_rsp_fifo.sv
// Result word queue decoupling the pipeline from the receiver.
module ahcr_rsp_fifo #(
   parameter int WIDTH = 53,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slots [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign pop_data  = slots[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(DEPTH)) |-> !push || pop)
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("result queue underflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/averaged_hysteresis_charge_relay.sv
// Top level: windowed averaging, hysteresis relay control and display scaling.
//
// Usage:
//   req_bus carries one word per ADC sampling event: voltage and current
//   samples plus a free-running millisecond timestamp. rsp_bus returns one
//   word per request, in order: relay state after the update, both rounded
//   window averages, and the two Q8.8-scaled display values (current is
//   offset-corrected and clamped at zero; both saturate at 65535).
//   csr_bus writes the six control registers by index; it is always ready
//   and should only be used while no request is in flight.
// Timing:
//   Throughput is one word per cycle while req_bus.ready is high: the
//   window memory is read at acceptance and written back the next cycle,
//   and consecutive items touch different slots. The result queue holds
//   RSP_FIFO_DEPTH words; req_bus.ready drops while that many words are
//   in flight or queued, so a stalled receiver backs up the input without
//   losing data.
// Reset:
//   Synchronous, active high. Window contents read as zero, sums and the
//   position go to zero, relay off, last switch time zero, registers to
//   their defaults. No clearing pass is needed.
module averaged_hysteresis_charge_relay #(
   parameter int WINDOW_LENGTH = 30,
   parameter int SAMPLE_BITS   = 10
) (
   input logic          clock,
   input logic          reset,
   ahcr_req_if.sink     req_bus,
   ahcr_rsp_if.source   rsp_bus,
   ahcr_csr_if.sink     csr_bus
);

   // ---------------------------------------------------------------------
   // Derived sizes
   // ---------------------------------------------------------------------
   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LENGTH + 1);
   localparam int NUM_W  = SUM_W + 1;                 // 2*sum + W
   localparam int DEN    = 2 * WINDOW_LENGTH;
   localparam int SHIFT  = NUM_W + $clog2(DEN);
   localparam int RECIP_W = SHIFT - $clog2(DEN) + 2;
   // ceil(2^SHIFT / DEN): exact floor division for any numerator < 2^NUM_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN));
   localparam int MUL_W  = NUM_W + RECIP_W;
   localparam int CMP_W  = ((SAMPLE_BITS > ahcr_pkg::LIMIT_W) ?
                            SAMPLE_BITS : ahcr_pkg::LIMIT_W) + 2;
   localparam int OFS_CMP_W = ((SAMPLE_BITS > ahcr_pkg::OFFSET_W) ?
                               SAMPLE_BITS : ahcr_pkg::OFFSET_W) + 1;
   localparam int PROD_W = SAMPLE_BITS + ahcr_pkg::GAIN_W + 1;
   localparam int RSP_W  = 1 + 2 * SAMPLE_BITS + 2 * ahcr_pkg::DISP_W;
   localparam int DEPTH  = ahcr_pkg::RSP_FIFO_DEPTH;
   localparam int OCC_W  = $clog2(DEPTH + 1);

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   logic [ahcr_pkg::LIMIT_W-1:0]   limit_ff;
   logic [ahcr_pkg::HYST_W-1:0]    hyst_ff;
   logic [ahcr_pkg::INERTIA_W-1:0] inertia_ff;
   logic [ahcr_pkg::GAIN_W-1:0]    vgain_ff;
   logic [ahcr_pkg::OFFSET_W-1:0]  offset_ff;
   logic [ahcr_pkg::GAIN_W-1:0]    cgain_ff;
   logic                           csr_wr;

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= ahcr_pkg::LIMIT_RST;
         hyst_ff    <= ahcr_pkg::HYST_RST;
         inertia_ff <= ahcr_pkg::INERTIA_RST;
         vgain_ff   <= ahcr_pkg::GAIN_RST;
         offset_ff  <= ahcr_pkg::OFFSET_RST;
         cgain_ff   <= ahcr_pkg::GAIN_RST;
      end else if (csr_wr) begin
         case (csr_bus.index)
            ahcr_pkg::CSR_CHARGE_LIMIT: begin
               limit_ff <= csr_bus.data[ahcr_pkg::LIMIT_W-1:0];
            end
            ahcr_pkg::CSR_HYSTERESIS: begin
               hyst_ff <= csr_bus.data[ahcr_pkg::HYST_W-1:0];
            end
            ahcr_pkg::CSR_INERTIA: begin
               inertia_ff <= csr_bus.data[ahcr_pkg::INERTIA_W-1:0];
            end
            ahcr_pkg::CSR_VOLTAGE_GAIN: begin
               vgain_ff <= csr_bus.data[ahcr_pkg::GAIN_W-1:0];
            end
            ahcr_pkg::CSR_CURRENT_OFFSET: begin
               offset_ff <= csr_bus.data[ahcr_pkg::OFFSET_W-1:0];
            end
            ahcr_pkg::CSR_CURRENT_GAIN: begin
               cgain_ff <= csr_bus.data[ahcr_pkg::GAIN_W-1:0];
            end
            default: begin
               // unmapped index: dropped
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input flow control: count words in flight plus queued
   // ---------------------------------------------------------------------
   logic             accept, pop;
   logic [OCC_W-1:0] occ_ff, occ_in;

   assign req_bus.ready = (occ_ff < OCC_W'(DEPTH));
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      occ_in = occ_ff;
      if (accept && !pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (pop && !accept) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1-2: window memory read, write-back and running sums
   // ---------------------------------------------------------------------
   logic             sum_vld;
   logic [SUM_W-1:0] vsum, csum;

   ahcr_window #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .SUM_W        (SUM_W)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .voltage_sample(req_bus.voltage_sample),
      .current_sample(req_bus.current_sample),
      .sum_valid     (sum_vld),
      .voltage_sum   (vsum),
      .current_sum   (csum)
   );

   // timestamp rides alongside the window pipeline
   ahcr_pkg::time_ms_type now_a_ff, now_b_ff, now_c_ff, now_d_ff;

   always_ff @(posedge clock) begin
      now_a_ff <= req_bus.now_ms;
      now_b_ff <= now_a_ff;
      now_c_ff <= now_b_ff;
      now_d_ff <= now_c_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 3: rounding numerators 2*sum + W
   // ---------------------------------------------------------------------
   logic             num_vld_ff;
   logic [NUM_W-1:0] vnum_ff, vnum_in, cnum_ff, cnum_in;

   assign vnum_in = {vsum, 1'b0} + NUM_W'(WINDOW_LENGTH);
   assign cnum_in = {csum, 1'b0} + NUM_W'(WINDOW_LENGTH);

   always_ff @(posedge clock) begin
      vnum_ff <= vnum_in;
      cnum_ff <= cnum_in;
   end

   // ---------------------------------------------------------------------
   // Stage 4: divide by 2W via reciprocal multiply
   // ---------------------------------------------------------------------
   logic             prod_vld_ff;
   logic [MUL_W-1:0] vq_ff, vq_in, cq_ff, cq_in;

   assign vq_in = MUL_W'(vnum_ff) * MUL_W'(RECIP);
   assign cq_in = MUL_W'(cnum_ff) * MUL_W'(RECIP);

   always_ff @(posedge clock) begin
      vq_ff <= vq_in;
      cq_ff <= cq_in;
   end

   // ---------------------------------------------------------------------
   // Stage 5: levels, relay decision, current offset
   // ---------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] vlev, clev;
   logic [CMP_W-1:0]       lev_x, lim_x, hyst_x;
   logic [OFS_CMP_W-1:0]   clev_x, ofs_x;
   logic                   below_band, above_band, may_switch, flip;
   ahcr_pkg::time_ms_type  elapsed;
   logic                   relay_ff, relay_in;
   ahcr_pkg::time_ms_type  last_ff, last_in;
   logic                   lvl_vld_ff;
   logic                   relay_e_ff;
   logic [SAMPLE_BITS-1:0] vlev_ff, clev_ff, cdiff_ff, cdiff_in;

   always_comb begin
      vlev   = vq_ff[SHIFT +: SAMPLE_BITS];
      clev   = cq_ff[SHIFT +: SAMPLE_BITS];
      lev_x  = CMP_W'(vlev);
      lim_x  = CMP_W'(limit_ff);
      hyst_x = CMP_W'(hyst_ff);
      // level < limit - hyst, without going negative
      below_band = (lev_x + hyst_x) < lim_x;
      above_band = lev_x > (lim_x + hyst_x);
      elapsed    = now_d_ff - last_ff;
      may_switch = elapsed > ahcr_pkg::TIME_W'(inertia_ff);
      flip       = prod_vld_ff && may_switch && (relay_ff ? above_band : below_band);
      relay_in   = relay_ff ^ flip;
      last_in    = flip ? now_d_ff : last_ff;
      clev_x     = OFS_CMP_W'(clev);
      ofs_x      = OFS_CMP_W'(offset_ff);
      cdiff_in   = (clev_x > ofs_x) ? SAMPLE_BITS'(clev_x - ofs_x) : '0;
   end

   always_ff @(posedge clock) begin
      vlev_ff    <= vlev;
      clev_ff    <= clev;
      cdiff_ff   <= cdiff_in;
      relay_e_ff <= relay_in;
   end

   // ---------------------------------------------------------------------
   // Stage 6: Q8.8 display products with rounding
   // ---------------------------------------------------------------------
   logic                   disp_vld_ff;
   logic                   relay_f_ff;
   logic [SAMPLE_BITS-1:0] vlev_f_ff, clev_f_ff;
   logic [PROD_W-1:0]      vprod_ff, vprod_in, cprod_ff, cprod_in;

   assign vprod_in = PROD_W'(vlev_ff) * PROD_W'(vgain_ff)
                   + PROD_W'(ahcr_pkg::ROUND_HALF);
   assign cprod_in = PROD_W'(cdiff_ff) * PROD_W'(cgain_ff)
                   + PROD_W'(ahcr_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      vprod_ff   <= vprod_in;
      cprod_ff   <= cprod_in;
      relay_f_ff <= relay_e_ff;
      vlev_f_ff  <= vlev_ff;
      clev_f_ff  <= clev_ff;
   end

   // saturate after the >>8; a zero offset difference still yields zero
   ahcr_pkg::disp_type vdisp, cdisp;

   assign vdisp = (|vprod_ff[PROD_W-1:ahcr_pkg::Q_FRAC+ahcr_pkg::DISP_W]) ?
                  '1 : vprod_ff[ahcr_pkg::Q_FRAC +: ahcr_pkg::DISP_W];
   assign cdisp = (|cprod_ff[PROD_W-1:ahcr_pkg::Q_FRAC+ahcr_pkg::DISP_W]) ?
                  '1 : cprod_ff[ahcr_pkg::Q_FRAC +: ahcr_pkg::DISP_W];

   // ---------------------------------------------------------------------
   // Stage valids, relay state, occupancy
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         num_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         lvl_vld_ff  <= 1'b0;
         disp_vld_ff <= 1'b0;
         relay_ff    <= 1'b0;
         last_ff     <= '0;
         occ_ff      <= '0;
      end else begin
         num_vld_ff  <= sum_vld;
         prod_vld_ff <= num_vld_ff;
         lvl_vld_ff  <= prod_vld_ff;
         disp_vld_ff <= lvl_vld_ff;
         relay_ff    <= relay_in;
         last_ff     <= last_in;
         occ_ff      <= occ_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue and output channel
   // ---------------------------------------------------------------------
   logic [RSP_W-1:0] push_word, pop_word;
   logic             rsp_has;

   assign push_word = {relay_f_ff, vlev_f_ff, clev_f_ff, vdisp, cdisp};
   assign pop       = rsp_has && rsp_bus.ready;

   ahcr_rsp_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (disp_vld_ff),
      .push_data(push_word),
      .pop      (pop),
      .not_empty(rsp_has),
      .pop_data (pop_word)
   );

   assign rsp_bus.valid = rsp_has;
   assign {rsp_bus.relay_on, rsp_bus.voltage_level, rsp_bus.current_level,
           rsp_bus.voltage_display, rsp_bus.current_display} = pop_word;

`ifndef SYNTHESIS
   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("in-flight count exceeds queue depth");

   a_relay_stamp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (relay_ff != $past(relay_ff)))
      |-> (last_ff == $past(now_d_ff)) && $past(prod_vld_ff))
      else $error("relay changed without a matching switch time");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> !rsp_has && !disp_vld_ff && !lvl_vld_ff)
      else $error("words present while nothing counted in flight");
`endif

endmodule

>>> tb/averaged_hysteresis_charge_relay_checker.sv
// Checker for the charge relay: predicts each result word and compares it.
module averaged_hysteresis_charge_relay_checker
   import ahcr_pkg::*;
#(
   parameter int WINDOW_LENGTH = 30,
   parameter int SAMPLE_BITS   = 10
) (
   input  logic clock,
   input  logic reset,
   ahcr_req_if  req_bus,
   ahcr_rsp_if  rsp_bus,
   ahcr_csr_if  csr_bus,
   output int   failures,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [SAMPLE_BITS-1:0] sample_t;

   typedef struct {
      logic     relay_on;
      sample_t  voltage_level;
      sample_t  current_level;
      disp_type voltage_display;
      disp_type current_display;
   } charge_report_t;

   // control registers as the block should hold them
   logic [LIMIT_W-1:0]   limit_cfg;
   logic [HYST_W-1:0]    hyst_cfg;
   logic [INERTIA_W-1:0] inertia_cfg;
   logic [GAIN_W-1:0]    vgain_cfg;
   logic [OFFSET_W-1:0]  offset_cfg;
   logic [GAIN_W-1:0]    cgain_cfg;

   // averaging windows and relay state
   sample_t     volt_hist [WINDOW_LENGTH];
   sample_t     curr_hist [WINDOW_LENGTH];
   int unsigned slot;
   int unsigned volt_sum;
   int unsigned curr_sum;
   logic        relay;
   time_ms_type last_switch;

   charge_report_t pending_reports[$];

   function automatic disp_type q88_scale(int unsigned value, int unsigned gain);
      longint unsigned prod;
      prod = (longint'(value) * longint'(gain) + ROUND_HALF) >> Q_FRAC;
      return (prod > 65535) ? '1 : disp_type'(prod);
   endfunction

   function automatic charge_report_t advance_charger(sample_t v, sample_t c,
                                                      time_ms_type now);
      charge_report_t rep;
      int unsigned    vlev;
      int unsigned    clev;
      time_ms_type    elapsed;
      logic           may_switch;
      slot = (slot == WINDOW_LENGTH - 1) ? 0 : slot + 1;
      volt_sum = volt_sum - volt_hist[slot] + v;
      curr_sum = curr_sum - curr_hist[slot] + c;
      volt_hist[slot] = v;
      curr_hist[slot] = c;
      // mean rounded half up
      vlev = (2 * volt_sum + WINDOW_LENGTH) / (2 * WINDOW_LENGTH);
      clev = (2 * curr_sum + WINDOW_LENGTH) / (2 * WINDOW_LENGTH);
      elapsed = now - last_switch;   // modulo 2^32
      may_switch = elapsed > inertia_cfg;
      if (!relay && int'(vlev) < int'(limit_cfg) - int'(hyst_cfg)) begin
         if (may_switch) begin
            relay = 1'b1;
            last_switch = now;
         end
      end else if (relay && int'(vlev) > int'(limit_cfg) + int'(hyst_cfg)) begin
         if (may_switch) begin
            relay = 1'b0;
            last_switch = now;
         end
      end
      rep.relay_on        = relay;
      rep.voltage_level   = sample_t'(vlev);
      rep.current_level   = sample_t'(clev);
      rep.voltage_display = q88_scale(vlev, vgain_cfg);
      rep.current_display = (clev > offset_cfg) ? q88_scale(clev - offset_cfg, cgain_cfg) : '0;
      return rep;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic check_report(charge_report_t want);
      if (rsp_bus.relay_on !== want.relay_on)
         report_mismatch($sformatf("relay_on got %0d want %0d",
                                   rsp_bus.relay_on, want.relay_on));
      if (rsp_bus.voltage_level !== want.voltage_level)
         report_mismatch($sformatf("voltage_level got %0d want %0d",
                                   rsp_bus.voltage_level, want.voltage_level));
      if (rsp_bus.current_level !== want.current_level)
         report_mismatch($sformatf("current_level got %0d want %0d",
                                   rsp_bus.current_level, want.current_level));
      if (rsp_bus.voltage_display !== want.voltage_display)
         report_mismatch($sformatf("voltage_display got %0d want %0d",
                                   rsp_bus.voltage_display, want.voltage_display));
      if (rsp_bus.current_display !== want.current_display)
         report_mismatch($sformatf("current_display got %0d want %0d",
                                   rsp_bus.current_display, want.current_display));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         limit_cfg   = LIMIT_RST;
         hyst_cfg    = HYST_RST;
         inertia_cfg = INERTIA_RST;
         vgain_cfg   = GAIN_RST;
         offset_cfg  = OFFSET_RST;
         cgain_cfg   = GAIN_RST;
         for (int i = 0; i < WINDOW_LENGTH; i++) begin
            volt_hist[i] = '0;
            curr_hist[i] = '0;
         end
         slot        = 0;
         volt_sum    = 0;
         curr_sum    = 0;
         relay       = 1'b0;
         last_switch = '0;
         pending_reports.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            // upper data bits beyond a register's width are dropped
            case (csr_bus.index)
               CSR_CHARGE_LIMIT:   limit_cfg   = csr_bus.data[LIMIT_W-1:0];
               CSR_HYSTERESIS:     hyst_cfg    = csr_bus.data[HYST_W-1:0];
               CSR_INERTIA:        inertia_cfg = csr_bus.data[INERTIA_W-1:0];
               CSR_VOLTAGE_GAIN:   vgain_cfg   = csr_bus.data[GAIN_W-1:0];
               CSR_CURRENT_OFFSET: offset_cfg  = csr_bus.data[OFFSET_W-1:0];
               CSR_CURRENT_GAIN:   cgain_cfg   = csr_bus.data[GAIN_W-1:0];
               default: ;
            endcase
         end
         // result first, so a word arriving with nothing pending is caught
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0)
               report_mismatch("result word with no sample pending");
            else
               check_report(pending_reports.pop_front());
         end
         if (req_bus.valid && req_bus.ready)
            pending_reports.push_back(advance_charger(req_bus.voltage_sample,
                                                      req_bus.current_sample,
                                                      req_bus.now_ms));
      end
      outstanding = pending_reports.size();
   end

endmodule

>>> tb/averaged_hysteresis_charge_relay_tb.sv
// Testbench top: stimulus, handshake pacing, register programming and verdict.
module averaged_hysteresis_charge_relay_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ahcr_pkg::*;

   localparam int WINDOW_LENGTH = 30;
   localparam int SAMPLE_BITS   = 10;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
   localparam int RESET_CYCLES  = 12;
   localparam int HOLD_CYCLES   = 300;     // long receiver stall
   localparam int DRAIN_CYCLES  = 24;      // tail after the last result
   localparam int RUN_LIMIT     = 400000;  // timeout, in clock cycles
   localparam int PHASES        = 6;
   localparam int PHASE_WORDS   = 108;

   // indexes with no register behind them
   localparam csr_index_type CSR_UNUSED_LO = 3'd6;
   localparam csr_index_type CSR_UNUSED_HI = 3'd7;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int failures;
   int outstanding;
   int cycle_count;

   // pacing controls shared between the sender and the receiver
   bit hold_rsp;
   bit rsp_eager;

   // what the stimulus believes the registers hold; steers the random sequences
   int limit_now;
   int hyst_now;
   int inertia_now;
   int offset_now;

   time_ms_type stamp;

   ahcr_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   ahcr_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   ahcr_csr_if                              csr_bus ();

   averaged_hysteresis_charge_relay #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   averaged_hysteresis_charge_relay_checker #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .failures   (failures),
      .outstanding(outstanding)
   );

   always #2 clock = ~clock;

   // hard stop if something hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("averaged_hysteresis_charge_relay_tb failed");
         $finish;
      end
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Gains: mostly around unity, sometimes anywhere in the full range.
   function automatic int rand_gain();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1024);
   endfunction

   function automatic sample_type clamp_sample(int value);
      return sample_type'((value < 0) ? 0 : (value > SAMPLE_MAX) ? SAMPLE_MAX : value);
   endfunction

   // Receiver: ready changes on the falling edge. A hold request parks it
   // so the result queue fills and req_bus.ready drops.
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!rsp_eager && $urandom_range(0, 3) == 0)
               stall = gap_len();
         end
      end
   end

   // Drop valid to leave a gap in the input.
   task automatic pause(int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
   endtask

   // Offer one sample word and wait until it is taken. Valid stays high
   // afterwards so back-to-back words need no idle cycle.
   task automatic send_word(sample_type v, sample_type c, time_ms_type t);
      @(negedge clock);
      req_bus.valid          = 1'b1;
      req_bus.voltage_sample = v;
      req_bus.current_sample = c;
      req_bus.now_ms         = t;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop sending and wait until every result word has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Program all six registers once the block is idle. Narrow registers get
   // junk in the unused upper data bits; those must be ignored.
   task automatic load_regs(int limit, int hyst, int inertia, int vgain, int offset,
                            int cgain);
      wait_idle();
      write_reg(CSR_CHARGE_LIMIT,
                csr_data_type'($urandom << LIMIT_W) | csr_data_type'(limit));
      write_reg(CSR_HYSTERESIS,
                csr_data_type'($urandom << HYST_W) | csr_data_type'(hyst));
      write_reg(CSR_INERTIA, csr_data_type'(inertia));
      write_reg(CSR_VOLTAGE_GAIN, csr_data_type'(vgain));
      write_reg(CSR_CURRENT_OFFSET,
                csr_data_type'($urandom << OFFSET_W) | csr_data_type'(offset));
      write_reg(CSR_CURRENT_GAIN, csr_data_type'(cgain));
      // writes to unmapped indexes must change nothing
      if ($urandom_range(0, 1))
         write_reg($urandom_range(0, 1) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                   csr_data_type'($urandom));
      limit_now   = limit;
      hyst_now    = hyst;
      inertia_now = inertia;
      offset_now  = offset;
   endtask

   // Random phase. Voltage runs alternate between well below and well above
   // the dead band so the window average actually crosses it and the relay
   // toggles; some noise words are mixed in. Current hovers around the
   // offset to hit both sides of the zero clamp. Timestamps mostly step by
   // amounts comparable to the inertia, sometimes jump anywhere.
   task automatic run_phase(int count, bit gapless, int hold_at, int drain_at);
      int  v;
      int  c;
      int  target;
      int  run_left;
      int  r;
      bit  high_run;
      run_left = 0;
      high_run = $urandom_range(0, 1);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at)
            hold_rsp = 1'b1;
         if (i == drain_at)
            wait_idle();
         if (run_left == 0) begin
            high_run = !high_run;
            run_left = $urandom_range(8, 50);
         end
         run_left--;
         target = high_run ? limit_now + hyst_now + int'($urandom_range(5, 150))
                           : limit_now - hyst_now - int'($urandom_range(5, 150));
         v = target + int'($urandom_range(0, 60)) - 30;
         if ($urandom_range(0, 9) == 0)
            v = $urandom_range(0, SAMPLE_MAX);
         c = offset_now + int'($urandom_range(0, 200)) - 100;
         if ($urandom_range(0, 4) == 0)
            c = $urandom_range(0, SAMPLE_MAX);
         r = $urandom_range(0, 99);
         if (r < 70)
            stamp += $urandom_range(0, 2 * inertia_now + 4);
         else if (r < 85)
            stamp += $urandom_range(0, 3);
         else if (r < 92)
            stamp += inertia_now + $urandom_range(0, 1);   // near the boundary
         else
            stamp = $urandom;
         // no idle cycles while the receiver is parked: keep the input pushing
         if (!gapless && !hold_rsp)
            pause(gap_len());
         send_word(clamp_sample(v), clamp_sample(c), stamp);
      end
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.voltage_sample = '0;
      req_bus.current_sample = '0;
      req_bus.now_ms         = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = CSR_CHARGE_LIMIT;
      csr_bus.data           = '0;
      hold_rsp               = 1'b0;
      rsp_eager              = 1'b0;
      limit_now              = LIMIT_RST;
      hyst_now               = HYST_RST;
      inertia_now            = INERTIA_RST;
      offset_now             = OFFSET_RST;
      stamp                  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults: relay off, last switch at 0, inertia 1000 ms.
      // Full-scale word at t=0 wants the relay on but inertia blocks it;
      // t=1000 is exactly the inertia (still blocked), t=1001 switches.
      send_word(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX), 32'd0);
      send_word('0, '0, 32'd1000);
      send_word('0, '0, 32'd1001);
      send_word(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX), 32'hFFFF_FFFF);

      // Zero limit and band, no inertia, max gains: relay drops at once
      // (elapsed time wraps).
      load_regs(0, 0, 0, 65535, 0, 65535);
      send_word(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX), 32'd5);
      send_word(sample_type'(SAMPLE_MAX), '0, 32'd6);

      // Limit below the band: on request can never fire.
      load_regs(0, 255, 0, GAIN_RST, OFFSET_RST, GAIN_RST);
      send_word('0, sample_type'(SAMPLE_MAX), 32'd7);
      send_word(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX), 32'd8);

      // Top limit and band, max inertia, zero gains, top offset: current
      // display clamps to zero; switch on only once 65536 ms have gone by.
      load_regs(1023, 255, 65535, 0, 1023, 0);
      send_word('0, sample_type'(SAMPLE_MAX), 32'd65540);
      send_word('0, sample_type'(SAMPLE_MAX), 32'd65541);
      send_word(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX), 32'd131077);
      send_word('0, '0, 32'h8000_0000);

      // Random phases, each with its own register setting.
      stamp = '0;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: load_regs(1023, 0, 0, 65535, 0, 65535);
            4: load_regs(0, 255, 65535, 0, 1023, 0);
            default: load_regs($urandom_range(150, 900), $urandom_range(0, 40),
                               $urandom_range(0, 300), rand_gain(),
                               $urandom_range(0, SAMPLE_MAX), rand_gain());
         endcase
         if (p == 3)
            stamp = 32'hFFFF_F000;   // walk the timestamp across the wrap
         rsp_eager = (p == 0 || p == 3);
         // phase 2 parks the receiver; phase 3 drains mid-stream
         run_phase(PHASE_WORDS, p == 0 || p == 5, (p == 2) ? 20 : -1,
                   (p == 3) ? 50 : -1);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("averaged_hysteresis_charge_relay_tb passed");
      end else begin
         $display("averaged_hysteresis_charge_relay_tb failed");
      end
      $finish;
   end

endmodule
